### sv/steering_position_servo_controller_top_macros.svh
// ----------------------------------------------------------------------------
// steering servo assertion macros
// shared property forms for the steering servo checks
// ----------------------------------------------------------------------------
`ifndef STEERING_POSITION_SERVO_CONTROLLER_TOP_MACROS_SVH
`define STEERING_POSITION_SERVO_CONTROLLER_TOP_MACROS_SVH

// same-cycle implication
`define SPSC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SPSC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/spsc_pkg.sv
// ----------------------------------------------------------------------------
// steering servo package
// shared types, codes and helper functions of the steering servo
// ----------------------------------------------------------------------------
package spsc_pkg;

   // command codes
   localparam logic [1:0] CMD_UPDATE = 2'd0;
   localparam logic [1:0] CMD_JOG    = 2'd1;
   localparam logic [1:0] CMD_STOP   = 2'd2;
   localparam logic [1:0] CMD_TARGET = 2'd3;

   // stop causes
   localparam logic [2:0] CAUSE_NONE     = 3'd0;
   localparam logic [2:0] CAUSE_STALL    = 3'd1;
   localparam logic [2:0] CAUSE_JOG_TO   = 3'd2;
   localparam logic [2:0] CAUSE_REACHED  = 3'd3;
   localparam logic [2:0] CAUSE_MOVE_TO  = 3'd4;
   localparam logic [2:0] CAUSE_FAULT    = 3'd5;
   localparam logic [2:0] CAUSE_COMMAND  = 3'd6;

   // drive modes
   localparam logic [1:0] MODE_IDLE = 2'd0;
   localparam logic [1:0] MODE_MOVE = 2'd1;
   localparam logic [1:0] MODE_JOG  = 2'd2;

   // register indexes
   localparam logic [2:0] REG_CENTER    = 3'd0;
   localparam logic [2:0] REG_LEFT      = 3'd1;
   localparam logic [2:0] REG_RIGHT     = 3'd2;
   localparam logic [2:0] REG_KP        = 3'd3;
   localparam logic [2:0] REG_MIN_DUTY  = 3'd4;
   localparam logic [2:0] REG_MAX_DUTY  = 3'd5;
   localparam logic [2:0] REG_TOLERANCE = 3'd6;
   localparam logic [2:0] REG_STALL_THR = 3'd7;

   // full scale percent in q8.8
   localparam logic [15:0] PCT_FULL = 16'd25600;

   // divider geometry: dividends stay below 2**26
   localparam int DIV_STEPS = 26;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_EXEC,
      ST_TDIV,
      ST_TAPPLY,
      ST_PMUL,
      ST_PSTART,
      ST_PDIV,
      ST_FIN
   } state_type;

   typedef enum logic [1:0] {
      MUL_ERR,
      MUL_TGT,
      MUL_PCT
   } mul_sel_type;

   typedef struct packed {
      logic        load;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        exec;
      logic        div_start;
      logic        div_pct;
      logic        div_step;
      logic        tapply;
      logic        res_load;
   } ctl_cmd_type;

   typedef struct packed {
      logic tgt_ok;
   } dp_status_type;

   typedef struct packed {
      logic [12:0] center_angle;
      logic [12:0] left_angle;
      logic [12:0] right_angle;
      logic [15:0] kp_gain;
      logic [7:0]  min_duty;
      logic [7:0]  max_duty;
      logic [11:0] position_tolerance;
      logic [12:0] stall_threshold;
   } cfg_type;

   // signed position relative to center, wrapping on 12 bits
   function automatic logic signed [12:0] rel_pos(input logic [11:0] ang,
                                                  input logic [11:0] ctr,
                                                  input logic inv);
      logic [11:0]        d;
      logic signed [12:0] r;
      d = ang - ctr;
      r = signed'({d[11], d});
      if (inv) begin
         r = -r;
      end
      return r;
   endfunction

endpackage

### sv/spsc_controller.sv
// ----------------------------------------------------------------------------
// steering servo controller
// sequences capture, multiply, state update, divisions and result load
// ----------------------------------------------------------------------------
module spsc_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  spsc_pkg::dp_status_type sts,
   output spsc_pkg::ctl_cmd_type   ctl
);
   import spsc_pkg::*;

   state_type              state_ff, state_in;
   logic [DIV_CNT_W-1:0]   cnt_ff, cnt_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      ctl          = '0;
      ctl.mul_sel  = MUL_ERR;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ctl.load = 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            ctl.mul_en  = 1'b1;
            ctl.mul_sel = sts.tgt_ok ? MUL_TGT : MUL_ERR;
            state_in    = ST_EXEC;
         end
         ST_EXEC: begin
            ctl.exec = 1'b1;
            if (sts.tgt_ok) begin
               ctl.div_start = 1'b1;
               cnt_in        = '0;
               state_in      = ST_TDIV;
            end else begin
               state_in = ST_PMUL;
            end
         end
         ST_TDIV: begin
            ctl.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_TAPPLY;
            end
         end
         ST_TAPPLY: begin
            ctl.tapply = 1'b1;
            state_in   = ST_PMUL;
         end
         ST_PMUL: begin
            ctl.mul_en  = 1'b1;
            ctl.mul_sel = MUL_PCT;
            state_in    = ST_PSTART;
         end
         ST_PSTART: begin
            ctl.div_start = 1'b1;
            ctl.div_pct   = 1'b1;
            cnt_in        = '0;
            state_in      = ST_PDIV;
         end
         ST_PDIV: begin
            ctl.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               ctl.res_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

### sv/spsc_datapath.sv
// ----------------------------------------------------------------------------
// steering servo datapath
// servo state, calibration, shared multiplier and restoring divider
// ----------------------------------------------------------------------------
module spsc_datapath #(
   parameter int JOG_DUTY        = 128,
   parameter int STALL_WINDOW_MS = 500,
   parameter int JOG_TIMEOUT_MS  = 300,
   parameter int MOVE_TIMEOUT_MS = 3000,
   parameter int CAL_MIN_SPAN    = 50
) (
   input  logic                    clock,
   input  logic                    reset,
   input  spsc_pkg::cfg_type       cfg,
   input  spsc_pkg::ctl_cmd_type   ctl,
   output spsc_pkg::dp_status_type sts,
   input  logic [1:0]              req_command,
   input  logic [31:0]             req_now_ms,
   input  logic [11:0]             req_raw_angle,
   input  logic                    req_read_ok,
   input  logic                    req_magnet_ok,
   input  logic signed [1:0]       req_jog_direction,
   input  logic signed [15:0]      req_target_percent,
   output logic signed [8:0]       rsp_motor_speed,
   output logic                    rsp_accepted,
   output logic                    rsp_sensor_healthy,
   output logic                    rsp_is_calibrated,
   output logic [1:0]              rsp_drive_mode,
   output logic [2:0]              rsp_stop_cause,
   output logic signed [15:0]      rsp_steering_percent
);
   import spsc_pkg::*;

   localparam logic signed [8:0] JogDrive   = 9'(JOG_DUTY);
   localparam logic [31:0]       StallWin   = 32'(STALL_WINDOW_MS);
   localparam logic [31:0]       JogWin     = 32'(JOG_TIMEOUT_MS);
   localparam logic [31:0]       MoveWin    = 32'(MOVE_TIMEOUT_MS);
   localparam logic [11:0]       MinSpan    = 12'(CAL_MIN_SPAN);

   // captured item
   logic [1:0]         cmd_ff;
   logic [31:0]        now_ff;
   logic [11:0]        raw_ff;
   logic               rd_ff, mag_ff;
   logic signed [1:0]  dir_ff;
   logic signed [15:0] pct_ff;

   // servo state
   logic [11:0]        angle_ff, angle_in;
   logic               good_ff, good_in;
   logic signed [12:0] target_ff, target_in;
   logic               move_ff, move_in;
   logic [31:0]        mst_ff, mst_in;
   logic signed [1:0]  jog_ff, jog_in;
   logic [31:0]        jrt_ff, jrt_in;
   logic signed [12:0] sref_ff, sref_in;
   logic [31:0]        sct_ff, sct_in;
   logic signed [8:0]  drive_ff, drive_in;
   logic               acc_ff, acc_in;
   logic [2:0]         cause_ff, cause_in;

   // arithmetic units
   logic [31:0]            prod_ff;
   logic [DIV_STEPS-1:0]   dvd_ff;
   logic [15:0]            rem_ff, dvs_ff;

   // calibration
   logic [11:0]        l_d, r_d, l_mag, r_mag, sr_mag, sl_mag;
   logic               cal_ok, cal_inv;
   logic signed [12:0] span_left, span_right, neg_left;

   assign l_d   = cfg.left_angle[11:0] - cfg.center_angle[11:0];
   assign r_d   = cfg.right_angle[11:0] - cfg.center_angle[11:0];
   assign l_mag = l_d[11] ? 12'(-l_d) : l_d;
   assign r_mag = r_d[11] ? 12'(-r_d) : r_d;
   assign cal_ok = !cfg.center_angle[12] && !cfg.left_angle[12] && !cfg.right_angle[12]
                   && (l_d != '0) && (r_d != '0) && (l_d[11] != r_d[11])
                   && (l_mag >= MinSpan) && (r_mag >= MinSpan);
   assign cal_inv    = cal_ok && r_d[11];
   assign span_left  = cal_inv ? -signed'({l_d[11], l_d}) : signed'({l_d[11], l_d});
   assign span_right = cal_inv ? -signed'({r_d[11], r_d}) : signed'({r_d[11], r_d});
   assign neg_left   = -span_left;
   assign sr_mag     = span_right[11:0];
   assign sl_mag     = neg_left[11:0];

   // positions
   logic signed [12:0] cur_upd, rel_now;
   logic [11:0]        rel_mag;
   logic signed [13:0] err, sdiff;
   logic [12:0]        err_mag;
   logic [13:0]        sdiff_mag;

   assign cur_upd  = rel_pos(rd_ff ? raw_ff : angle_ff, cfg.center_angle[11:0], cal_inv);
   assign rel_now  = rel_pos(angle_ff, cfg.center_angle[11:0], cal_inv);
   assign rel_mag  = rel_now[12] ? 12'(-rel_now) : rel_now[11:0];
   assign err      = 14'(target_ff) - 14'(cur_upd);
   assign err_mag  = err[13] ? 13'(-err) : err[12:0];
   assign sdiff    = 14'(cur_upd) - 14'(sref_ff);
   assign sdiff_mag = sdiff[13] ? 14'(-sdiff) : 14'(sdiff);

   // target percent clamp
   logic signed [15:0] pctc;
   logic [14:0]        pct_mag;
   logic [11:0]        tspan;

   always_comb begin
      if (pct_ff > signed'(PCT_FULL)) begin
         pctc = signed'(PCT_FULL);
      end else if (pct_ff < -signed'(PCT_FULL)) begin
         pctc = -signed'(PCT_FULL);
      end else begin
         pctc = pct_ff;
      end
   end
   assign pct_mag = pctc[15] ? 15'(-pctc) : pctc[14:0];
   assign tspan   = pctc[15] ? sl_mag : sr_mag;
   assign sts.tgt_ok = (cmd_ff == CMD_TARGET) && cal_ok && good_ff;

   // shared multiplier operands
   logic [15:0] mul_a, mul_b;

   always_comb begin
      case (ctl.mul_sel)
         MUL_TGT: begin
            mul_a = 16'(pct_mag);
            mul_b = 16'(tspan);
         end
         MUL_PCT: begin
            mul_a = 16'(rel_mag);
            mul_b = PCT_FULL;
         end
         default: begin
            mul_a = 16'(err_mag);
            mul_b = cfg.kp_gain;
         end
      endcase
   end

   // duty clamp from the registered product
   logic [31:0] duty_lo, duty_cl, min_full, max_full;
   logic signed [8:0] duty_s;

   assign min_full = {16'b0, cfg.min_duty, 8'b0};
   assign max_full = {16'b0, cfg.max_duty, 8'b0};
   assign duty_lo  = (prod_ff < min_full) ? min_full : prod_ff;
   assign duty_cl  = (duty_lo > max_full) ? max_full : duty_lo;
   assign duty_s   = signed'({1'b0, duty_cl[15:8]});

   // divider step
   logic [16:0] div_sh, div_sub;
   logic        div_bit;

   assign div_sh  = {rem_ff, dvd_ff[DIV_STEPS-1]};
   assign div_bit = (div_sh >= {1'b0, dvs_ff});
   assign div_sub = div_sh - {1'b0, dvs_ff};

   // target from quotient
   logic signed [13:0] tq, tq_s, tgt_cl;

   assign tq     = signed'({1'b0, dvd_ff[12:0]});
   assign tq_s   = pctc[15] ? -tq : tq;
   assign tgt_cl = (tq_s < 14'(span_left)) ? 14'(span_left) :
                   (tq_s > 14'(span_right)) ? 14'(span_right) : tq_s;

   // readback percent from quotient
   logic [15:0]        pq;
   logic signed [15:0] pct_out;

   assign pq = (dvd_ff > DIV_STEPS'(PCT_FULL)) ? PCT_FULL : dvd_ff[15:0];
   assign pct_out = !cal_ok ? 16'sd0 : (rel_now[12] ? -signed'(pq) : signed'(pq));

   // servo state update
   always_comb begin
      logic              stalled;
      logic signed [1:0] dir_n;
      stalled   = 1'b0;
      dir_n     = dir_ff[1] ? -2'sd1 : dir_ff;
      angle_in  = angle_ff;
      good_in   = good_ff;
      target_in = target_ff;
      move_in   = move_ff;
      mst_in    = mst_ff;
      jog_in    = jog_ff;
      jrt_in    = jrt_ff;
      sref_in   = sref_ff;
      sct_in    = sct_ff;
      drive_in  = drive_ff;
      acc_in    = acc_ff;
      cause_in  = cause_ff;
      if (ctl.exec) begin
         acc_in   = 1'b0;
         cause_in = CAUSE_NONE;
         case (cmd_ff)
            CMD_UPDATE: begin
               if (rd_ff) begin
                  angle_in = raw_ff;
               end
               good_in = rd_ff && mag_ff;
               acc_in  = rd_ff && mag_ff;
               if (!(rd_ff && mag_ff)) begin
                  drive_in = '0; move_in = 1'b0; jog_in = '0;
                  cause_in = CAUSE_FAULT;
               end else begin
                  // stall window check
                  if ((move_ff || jog_ff != 2'sd0) && (now_ff - sct_ff >= StallWin)) begin
                     if (sdiff_mag < {1'b0, cfg.stall_threshold}) begin
                        drive_in = '0; move_in = 1'b0; jog_in = '0;
                        cause_in = CAUSE_STALL;
                        stalled  = 1'b1;
                     end else begin
                        sref_in = cur_upd;
                        sct_in  = now_ff;
                     end
                  end
                  if (!stalled) begin
                     if (jog_ff != 2'sd0) begin
                        if (now_ff - jrt_ff >= JogWin) begin
                           drive_in = '0; move_in = 1'b0; jog_in = '0;
                           cause_in = CAUSE_JOG_TO;
                        end
                     end else if (move_ff) begin
                        if (err_mag <= {1'b0, cfg.position_tolerance}) begin
                           drive_in = '0; move_in = 1'b0; jog_in = '0;
                           cause_in = CAUSE_REACHED;
                        end else if (now_ff - mst_ff >= MoveWin) begin
                           drive_in = '0; move_in = 1'b0; jog_in = '0;
                           cause_in = CAUSE_MOVE_TO;
                        end else begin
                           drive_in = err[13] ? -duty_s : duty_s;
                        end
                     end
                  end
               end
            end
            CMD_JOG: begin
               if (dir_ff == 2'sd0) begin
                  if (jog_ff != 2'sd0) begin
                     drive_in = '0; move_in = 1'b0; jog_in = '0;
                     cause_in = CAUSE_COMMAND;
                  end
               end else if (good_ff) begin
                  move_in = 1'b0;
                  if (jog_ff != dir_n) begin
                     sref_in = rel_now;
                     sct_in  = now_ff;
                  end
                  jog_in   = dir_n;
                  jrt_in   = now_ff;
                  drive_in = dir_n[1] ? -JogDrive : JogDrive;
               end
            end
            CMD_STOP: begin
               drive_in = '0; move_in = 1'b0; jog_in = '0;
               cause_in = CAUSE_COMMAND;
            end
            CMD_TARGET: begin
               if (sts.tgt_ok) begin
                  jog_in  = '0;
                  move_in = 1'b1;
                  mst_in  = now_ff;
                  sref_in = rel_now;
                  sct_in  = now_ff;
                  acc_in  = 1'b1;
               end
            end
            default: ;
         endcase
      end
      if (ctl.tapply) begin
         target_in = tgt_cl[12:0];
      end
   end

   // control state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         angle_ff  <= '0;
         good_ff   <= 1'b0;
         target_ff <= '0;
         move_ff   <= 1'b0;
         mst_ff    <= '0;
         jog_ff    <= '0;
         jrt_ff    <= '0;
         sref_ff   <= '0;
         sct_ff    <= '0;
         drive_ff  <= '0;
         acc_ff    <= 1'b0;
         cause_ff  <= CAUSE_NONE;
      end else begin
         angle_ff  <= angle_in;
         good_ff   <= good_in;
         target_ff <= target_in;
         move_ff   <= move_in;
         mst_ff    <= mst_in;
         jog_ff    <= jog_in;
         jrt_ff    <= jrt_in;
         sref_ff   <= sref_in;
         sct_ff    <= sct_in;
         drive_ff  <= drive_in;
         acc_ff    <= acc_in;
         cause_ff  <= cause_in;
      end
   end

   // item capture, multiplier, divider and result registers
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         cmd_ff <= req_command;
         now_ff <= req_now_ms;
         raw_ff <= req_raw_angle;
         rd_ff  <= req_read_ok;
         mag_ff <= req_magnet_ok;
         dir_ff <= req_jog_direction;
         pct_ff <= req_target_percent;
      end
      if (ctl.mul_en) begin
         prod_ff <= 32'(mul_a) * 32'(mul_b);
      end
      if (ctl.div_start) begin
         dvd_ff <= prod_ff[DIV_STEPS-1:0];
         rem_ff <= '0;
         dvs_ff <= ctl.div_pct ? 16'(rel_now[12] ? sl_mag : sr_mag) : PCT_FULL;
      end else if (ctl.div_step) begin
         dvd_ff <= {dvd_ff[DIV_STEPS-2:0], div_bit};
         rem_ff <= div_bit ? div_sub[15:0] : div_sh[15:0];
      end
      if (ctl.res_load) begin
         rsp_motor_speed      <= drive_ff;
         rsp_accepted         <= acc_ff;
         rsp_sensor_healthy   <= good_ff;
         rsp_is_calibrated    <= cal_ok;
         rsp_drive_mode       <= (jog_ff != 2'sd0) ? MODE_JOG : (move_ff ? MODE_MOVE : MODE_IDLE);
         rsp_stop_cause       <= cause_ff;
         rsp_steering_percent <= pct_out;
      end
   end

endmodule

### sv/steering_position_servo_controller_top.sv
// sequence: capture, multiply, state update, percent multiply, percent divide, result
// load; an accepted set target adds a target divide and apply; both divides use the 26-step
// restoring divider; no new item is taken until the result load, which output stalls hold
// reset: synchronous, clears servo state, calibration registers to not captured
// ----------------------------------------------------------------------------
// steering position servo controller
// top level with apb-style register file, controller and datapath
// ----------------------------------------------------------------------------
`include "steering_position_servo_controller_top_macros.svh"

module steering_position_servo_controller_top #(
   parameter int JOG_DUTY        = 128,
   parameter int STALL_WINDOW_MS = 500,
   parameter int JOG_TIMEOUT_MS  = 300,
   parameter int MOVE_TIMEOUT_MS = 3000,
   parameter int CAL_MIN_SPAN    = 50
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_command,
   input  logic [31:0]        req_now_ms,
   input  logic [11:0]        req_raw_angle,
   input  logic               req_read_ok,
   input  logic               req_magnet_ok,
   input  logic signed [1:0]  req_jog_direction,
   input  logic signed [15:0] req_target_percent,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [8:0]  rsp_motor_speed,
   output logic               rsp_accepted,
   output logic               rsp_sensor_healthy,
   output logic               rsp_is_calibrated,
   output logic [1:0]         rsp_drive_mode,
   output logic [2:0]         rsp_stop_cause,
   output logic signed [15:0] rsp_steering_percent,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [4:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);
   import spsc_pkg::*;

   cfg_type       cfg_ff, cfg_in;
   ctl_cmd_type   ctl;
   dp_status_type sts;
   logic          wr_en;
   logic [2:0]    reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_idx    = csr_paddr[4:2];

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_CENTER:    cfg_in.center_angle       = csr_pwdata[12:0];
            REG_LEFT:      cfg_in.left_angle         = csr_pwdata[12:0];
            REG_RIGHT:     cfg_in.right_angle        = csr_pwdata[12:0];
            REG_KP:        cfg_in.kp_gain            = csr_pwdata[15:0];
            REG_MIN_DUTY:  cfg_in.min_duty           = csr_pwdata[7:0];
            REG_MAX_DUTY:  cfg_in.max_duty           = csr_pwdata[7:0];
            REG_TOLERANCE: cfg_in.position_tolerance = csr_pwdata[11:0];
            REG_STALL_THR: cfg_in.stall_threshold    = csr_pwdata[12:0];
            default: ;
         endcase
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.center_angle       <= 13'h1FFF;
         cfg_ff.left_angle         <= 13'h1FFF;
         cfg_ff.right_angle        <= 13'h1FFF;
         cfg_ff.kp_gain            <= 16'd256;
         cfg_ff.min_duty           <= 8'd40;
         cfg_ff.max_duty           <= 8'd255;
         cfg_ff.position_tolerance <= 12'd10;
         cfg_ff.stall_threshold    <= 13'd5;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // register read mux
   always_comb begin
      unique case (reg_idx)
         REG_CENTER:    csr_prdata = 32'(cfg_ff.center_angle);
         REG_LEFT:      csr_prdata = 32'(cfg_ff.left_angle);
         REG_RIGHT:     csr_prdata = 32'(cfg_ff.right_angle);
         REG_KP:        csr_prdata = 32'(cfg_ff.kp_gain);
         REG_MIN_DUTY:  csr_prdata = 32'(cfg_ff.min_duty);
         REG_MAX_DUTY:  csr_prdata = 32'(cfg_ff.max_duty);
         REG_TOLERANCE: csr_prdata = 32'(cfg_ff.position_tolerance);
         REG_STALL_THR: csr_prdata = 32'(cfg_ff.stall_threshold);
         default:       csr_prdata = '0;
      endcase
   end

   spsc_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .ctl       (ctl)
   );

   spsc_datapath #(
      .JOG_DUTY        (JOG_DUTY),
      .STALL_WINDOW_MS (STALL_WINDOW_MS),
      .JOG_TIMEOUT_MS  (JOG_TIMEOUT_MS),
      .MOVE_TIMEOUT_MS (MOVE_TIMEOUT_MS),
      .CAL_MIN_SPAN    (CAL_MIN_SPAN)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .cfg                  (cfg_ff),
      .ctl                  (ctl),
      .sts                  (sts),
      .req_command          (req_command),
      .req_now_ms           (req_now_ms),
      .req_raw_angle        (req_raw_angle),
      .req_read_ok          (req_read_ok),
      .req_magnet_ok        (req_magnet_ok),
      .req_jog_direction    (req_jog_direction),
      .req_target_percent   (req_target_percent),
      .rsp_motor_speed      (rsp_motor_speed),
      .rsp_accepted         (rsp_accepted),
      .rsp_sensor_healthy   (rsp_sensor_healthy),
      .rsp_is_calibrated    (rsp_is_calibrated),
      .rsp_drive_mode       (rsp_drive_mode),
      .rsp_stop_cause       (rsp_stop_cause),
      .rsp_steering_percent (rsp_steering_percent)
   );

   // result flags for the checks
   logic rsp_stopped, rsp_idle;

   assign rsp_stopped = rsp_valid && (rsp_stop_cause != CAUSE_NONE);
   assign rsp_idle    = rsp_valid && (rsp_drive_mode == MODE_IDLE);

   // checks
   `SPSC_ASSERT_NEXT(a_busy, req_valid && !req_stall, req_stall, "not busy after transfer")
   `SPSC_ASSERT_NOW(a_stop_drive, rsp_stopped, rsp_motor_speed == 9'sd0, "drive on after stop")
   `SPSC_ASSERT_NOW(a_idle_drive, rsp_idle, rsp_motor_speed == 9'sd0, "drive on while idle")
   `SPSC_ASSERT_NOW(a_acc_ok, rsp_valid && rsp_accepted, rsp_sensor_healthy, "accept unhealthy")

endmodule
